// File: rtl/matu_pkg.sv
// shared types and constants for the memory chunk address translation unit
// no dependencies; used by every rtl file of the block by scoped names

package matu_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned MAX_CHUNKS  = 4;
  localparam int unsigned CHUNK_IDX_W = 2;
  // eight 32-bit registers at byte addresses 4*i
  localparam int unsigned PADDR_W     = 5;
  localparam int unsigned REG_IDX_W   = 3;

  localparam int unsigned       NUM_CHUNKS_DEF = 4;
  localparam logic [DATA_W-1:0] VIRT_BASE_DEF  = 32'h0000_0000;
  localparam logic [DATA_W-1:0] ALL_ONES       = '1;

  typedef enum logic [1:0] {
    ACT_V2P = 2'd0,
    ACT_P2V = 2'd1,
    ACT_END = 2'd2
  } matu_action_e;

  // one table entry plus the values derived from it at write time
  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] vstart;     // virtual start of the chunk
    logic [DATA_W-1:0] chunk_end;  // base + size
  } matu_chunk_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [DATA_W-1:0] address;
    logic [DATA_W-1:0] length;
  } matu_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]      address;
    logic                   found;
    logic [CHUNK_IDX_W-1:0] index;
  } matu_result_t;

endpackage

// File: rtl/matu_cfg_regs.sv
// apb register file holding the chunk table and its derived virtual starts and ends
// depends on matu_pkg

module matu_cfg_regs #(
  parameter logic [matu_pkg::DATA_W-1:0] VIRT_BASE = matu_pkg::VIRT_BASE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [matu_pkg::PADDR_W-1:0]   paddr,
  input  logic [matu_pkg::DATA_W-1:0]    pwdata,
  output logic [matu_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output matu_pkg::matu_chunk_t          chunks_o [matu_pkg::MAX_CHUNKS]
);

  matu_pkg::matu_chunk_t                   chunk_q [matu_pkg::MAX_CHUNKS];
  matu_pkg::matu_chunk_t                   chunk_d [matu_pkg::MAX_CHUNKS];
  logic [matu_pkg::REG_IDX_W-1:0]          reg_idx;
  logic [matu_pkg::CHUNK_IDX_W-1:0]        sel;
  logic                                    wr_en;
  logic [matu_pkg::DATA_W-1:0]             size_delta;

  assign pready  = 1'b1;
  assign reg_idx = paddr[matu_pkg::PADDR_W-1:2];
  assign sel     = reg_idx[matu_pkg::REG_IDX_W-1:1];
  assign wr_en   = psel && penable && pwrite && pready;
  // change in size applies to the virtual start of every later chunk
  assign size_delta = pwdata - chunk_q[sel].size;

  always_comb begin
    chunk_d = chunk_q;
    if (wr_en) begin
      if (reg_idx[0]) begin
        chunk_d[sel].size      = pwdata;
        chunk_d[sel].chunk_end = chunk_q[sel].base + pwdata;
        for (int i = 1; i < int'(matu_pkg::MAX_CHUNKS); i++) begin
          if (sel < matu_pkg::CHUNK_IDX_W'(i)) begin
            chunk_d[i].vstart = chunk_q[i].vstart + size_delta;
          end
        end
      end else begin
        chunk_d[sel].base      = pwdata;
        chunk_d[sel].chunk_end = pwdata + chunk_q[sel].size;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(matu_pkg::MAX_CHUNKS); i++) begin
        chunk_q[i].base      <= '0;
        chunk_q[i].size      <= '0;
        chunk_q[i].vstart    <= VIRT_BASE;
        chunk_q[i].chunk_end <= '0;
      end
    end else begin
      chunk_q <= chunk_d;
    end
  end

  assign prdata   = reg_idx[0] ? chunk_q[sel].size : chunk_q[sel].base;
  assign chunks_o = chunk_q;

endmodule

// File: rtl/matu_xlate.sv
// combinational lookup: one compare lane per chunk and a lowest-index priority pick
// depends on matu_pkg

module matu_xlate #(
  parameter int unsigned NUM_CHUNKS = matu_pkg::NUM_CHUNKS_DEF
) (
  input  matu_pkg::matu_item_t   item_i,
  input  matu_pkg::matu_chunk_t  chunks_i [matu_pkg::MAX_CHUNKS],
  output matu_pkg::matu_result_t result_o
);

  logic [matu_pkg::DATA_W-1:0] lane_addr [NUM_CHUNKS];
  logic [NUM_CHUNKS-1:0]       lane_hit;
  logic [matu_pkg::DATA_W-1:0] end_addr;

  assign end_addr = item_i.address + item_i.length;

  for (genvar i = 0; i < NUM_CHUNKS; i++) begin : g_lane
    logic [matu_pkg::DATA_W-1:0] voff;
    logic [matu_pkg::DATA_W-1:0] poff;

    assign voff = item_i.address - chunks_i[i].vstart;
    assign poff = item_i.address - chunks_i[i].base;

    always_comb begin
      lane_addr[i] = matu_pkg::ALL_ONES;
      lane_hit[i]  = 1'b0;
      unique case (matu_pkg::matu_action_e'(item_i.action))
        matu_pkg::ACT_V2P: begin
          lane_hit[i]  = voff < chunks_i[i].size;
          lane_addr[i] = chunks_i[i].base + voff;
        end
        matu_pkg::ACT_P2V: begin
          lane_hit[i]  = poff < chunks_i[i].size;
          lane_addr[i] = chunks_i[i].vstart + poff;
        end
        matu_pkg::ACT_END: begin
          lane_hit[i] = (chunks_i[i].size != '0) && (chunks_i[i].chunk_end == end_addr);
        end
        default: begin
          lane_hit[i] = 1'b0;
        end
      endcase
    end
  end

  // walk down so the lowest hitting lane wins
  always_comb begin
    result_o.address = matu_pkg::ALL_ONES;
    result_o.found   = 1'b0;
    result_o.index   = '0;
    for (int i = int'(NUM_CHUNKS) - 1; i >= 0; i--) begin
      if (lane_hit[i]) begin
        result_o.address = lane_addr[i];
        result_o.found   = 1'b1;
        result_o.index   = matu_pkg::CHUNK_IDX_W'(i);
      end
    end
  end

endmodule

// File: rtl/memory_chunk_address_translation_unit.sv
// top level of the memory chunk address translation unit: input and result registers
// depends on matu_pkg, matu_cfg_regs and matu_xlate
//
// usage
// - input channel (in_valid_i / in_ready_o) carries one beat per request: action_i,
//   address_i and length_i. action 0 maps a virtual address to physical, 1 maps a
//   physical address to virtual, 2 tests whether address + length ends a chunk
// - output channel (out_valid_o / out_ready_i) returns one beat per request:
//   result_address_o, found_o and chunk_index_o; a miss gives all ones, found low,
//   index zero; the end test always gives all ones as address
// - the apb port writes the chunk table; each write also updates the chunk end, and a
//   size write also updates the virtual start of later chunks, so the table is ready on the next cycle
// - an accepted input beat passes the input register and then the result register; one
//   beat per cycle is sustained while the receiver takes every beat, as the lane compares
//   and the pick all fit between the input register and the result register
// - when the receiver stalls, the result register holds its beat and the input
//   register still takes one more beat; in_ready_o drops only while both are full
// - reset clears the chunk table (all chunks unused) and empties both registers

module memory_chunk_address_translation_unit #(
  parameter int unsigned                 NUM_CHUNKS = matu_pkg::NUM_CHUNKS_DEF,
  parameter logic [matu_pkg::DATA_W-1:0] VIRT_BASE  = matu_pkg::VIRT_BASE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // apb configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [matu_pkg::PADDR_W-1:0]        paddr,
  input  logic [matu_pkg::DATA_W-1:0]         pwdata,
  output logic [matu_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          action_i,
  input  logic [matu_pkg::DATA_W-1:0]         address_i,
  input  logic [matu_pkg::DATA_W-1:0]         length_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [matu_pkg::DATA_W-1:0]         result_address_o,
  output logic                                found_o,
  output logic [matu_pkg::CHUNK_IDX_W-1:0]    chunk_index_o
);

  matu_pkg::matu_chunk_t  chunks [matu_pkg::MAX_CHUNKS];
  matu_pkg::matu_item_t   item_q;
  matu_pkg::matu_result_t result_d;
  matu_pkg::matu_result_t result_q;
  logic                   item_valid_q;
  logic                   item_valid_d;
  logic                   out_valid_q;
  logic                   out_valid_d;
  logic                   res_ready;
  logic                   in_beat;

  matu_cfg_regs #(
    .VIRT_BASE (VIRT_BASE)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .chunks_o (chunks)
  );

  matu_xlate #(
    .NUM_CHUNKS (NUM_CHUNKS)
  ) u_xlate (
    .item_i   (item_q),
    .chunks_i (chunks),
    .result_o (result_d)
  );

  // result register frees up when empty or its beat leaves this cycle
  assign res_ready  = !out_valid_q || out_ready_i;
  assign in_ready_o = !item_valid_q || res_ready;
  assign in_beat    = in_valid_i && in_ready_o;

  always_comb begin
    item_valid_d = item_valid_q;
    out_valid_d  = out_valid_q;
    if (in_ready_o) begin
      item_valid_d = in_valid_i;
    end
    if (res_ready) begin
      out_valid_d = item_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      item_q.action  <= action_i;
      item_q.address <= address_i;
      item_q.length  <= length_i;
    end
    if (res_ready && item_valid_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = result_q.address;
  assign found_o          = result_q.found;
  assign chunk_index_o    = result_q.index;

endmodule

// File: rtl/matu_checker.sv
// port-level checks for the memory chunk address translation unit, bound to the top level
// depends on matu_pkg and memory_chunk_address_translation_unit

module matu_checker #(
  parameter int unsigned NUM_CHUNKS = matu_pkg::NUM_CHUNKS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [matu_pkg::DATA_W-1:0]      result_address_o,
  input logic                             found_o,
  input logic [matu_pkg::CHUNK_IDX_W-1:0] chunk_index_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_address_o)
      && $stable(found_o) && $stable(chunk_index_o))
    else $error("result beat changed while stalled");

  // a miss reports all ones and index zero
  a_miss_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> result_address_o == matu_pkg::ALL_ONES
      && chunk_index_o == '0)
    else $error("miss beat carries wrong address or index");

  // a hit names a searched chunk
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> 32'(chunk_index_o) < NUM_CHUNKS)
    else $error("hit on a chunk outside the searched range");

  // back-pressure only while the result beat is stalled
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

endmodule

bind memory_chunk_address_translation_unit matu_checker #(
  .NUM_CHUNKS (NUM_CHUNKS)
) u_matu_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .result_address_o (result_address_o),
  .found_o          (found_o),
  .chunk_index_o    (chunk_index_o)
);

// File: sim/memory_chunk_address_translation_unit_checker.sv
// register map codes shared by the test and a checker that predicts and compares every result beat
// depends on matu_pkg; instantiated next to the dut by memory_chunk_address_translation_unit_test
`timescale 1ns / 1ps

package matu_test_pkg;

  // register index = chunk * REGS_PER_CHUNK + field offset
  localparam int unsigned REGS_PER_CHUNK = 2;
  localparam int unsigned REG_PHYS_BASE  = 0;
  localparam int unsigned REG_SIZE       = 1;

  // action code the block does not define
  localparam logic [1:0]  ACT_UNDEF      = 2'd3;

endpackage

module memory_chunk_address_translation_unit_checker
  import matu_pkg::*;
  import matu_test_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]      pwdata,
  input  logic                   pready,
  input  logic                   in_valid_i,
  input  logic                   in_ready_o,
  input  logic [1:0]             action_i,
  input  logic [DATA_W-1:0]      address_i,
  input  logic [DATA_W-1:0]      length_i,
  input  logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  logic [DATA_W-1:0]      result_address_o,
  input  logic                   found_o,
  input  logic [CHUNK_IDX_W-1:0] chunk_index_o,
  output int unsigned            mismatch_count_o,
  output int unsigned            pending_o
);

  localparam int unsigned SEARCHED_CHUNKS =
      (NUM_CHUNKS_DEF > MAX_CHUNKS) ? MAX_CHUNKS : NUM_CHUNKS_DEF;

  logic [DATA_W-1:0] phys_base_q [MAX_CHUNKS];
  logic [DATA_W-1:0] chunk_size_q [MAX_CHUNKS];
  matu_result_t      expected_results_q [$];

  function automatic matu_result_t predict_translation(input logic [1:0] act,
                                                       input logic [DATA_W-1:0] addr,
                                                       input logic [DATA_W-1:0] len);
    matu_result_t      res;
    logic [DATA_W-1:0] voff;
    logic [DATA_W-1:0] vstart;
    logic [DATA_W-1:0] poff;
    logic [DATA_W-1:0] span_end;
    res.address = ALL_ONES;
    res.found   = 1'b0;
    res.index   = '0;
    voff        = addr - VIRT_BASE_DEF;
    vstart      = VIRT_BASE_DEF;
    span_end    = addr + len;
    // lowest matching chunk wins
    for (int unsigned c = 0; c < SEARCHED_CHUNKS; c++) begin
      if (!res.found) begin
        poff = addr - phys_base_q[c];
        case (act)
          ACT_V2P: begin
            if (voff < chunk_size_q[c]) begin
              res.address = phys_base_q[c] + voff;
              res.found   = 1'b1;
              res.index   = CHUNK_IDX_W'(c);
            end else begin
              voff = voff - chunk_size_q[c];
            end
          end
          ACT_P2V: begin
            if (poff < chunk_size_q[c]) begin
              res.address = vstart + poff;
              res.found   = 1'b1;
              res.index   = CHUNK_IDX_W'(c);
            end else begin
              vstart = vstart + chunk_size_q[c];
            end
          end
          ACT_END: begin
            if (chunk_size_q[c] != '0 && phys_base_q[c] + chunk_size_q[c] == span_end) begin
              res.found = 1'b1;
              res.index = CHUNK_IDX_W'(c);
            end
          end
          default: ;
        endcase
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [REG_IDX_W-1:0] reg_idx;
    matu_result_t         want;
    if (!rst_ni) begin
      for (int unsigned c = 0; c < MAX_CHUNKS; c++) begin
        phys_base_q[c]  = '0;
        chunk_size_q[c] = '0;
      end
      expected_results_q.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        reg_idx = paddr[2 +: REG_IDX_W];
        if (reg_idx % REGS_PER_CHUNK == REG_SIZE) begin
          chunk_size_q[reg_idx / REGS_PER_CHUNK] = pwdata;
        end else begin
          phys_base_q[reg_idx / REGS_PER_CHUNK] = pwdata;
        end
      end
      // retire before pushing so a same-cycle request never matches itself
      if (out_valid_o && out_ready_i) begin
        if (expected_results_q.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatch_count_o++;
        end else begin
          want = expected_results_q.pop_front();
          if (result_address_o !== want.address) begin
            $error("result_address mismatch: expected %08h, actual %08h",
                   want.address, result_address_o);
            mismatch_count_o++;
          end
          if (found_o !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, found_o);
            mismatch_count_o++;
          end
          if (chunk_index_o !== want.index) begin
            $error("chunk_index mismatch: expected %0d, actual %0d", want.index, chunk_index_o);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_results_q.push_back(predict_translation(action_i, address_i, length_i));
      end
      pending_o = expected_results_q.size();
    end
  end

endmodule

// File: sim/memory_chunk_address_translation_unit_test.sv
// stimulus and verdict for the memory chunk address translation unit
// depends on matu_pkg, matu_test_pkg and memory_chunk_address_translation_unit_checker
`timescale 1ns / 1ps

module memory_chunk_address_translation_unit_test;
  import matu_pkg::*;
  import matu_test_pkg::*;

  // generous bound: every item waiting out a long receiver stall, plus table writes
  localparam int unsigned CYCLE_LIMIT     = 400_000;
  // extra idle margin after the last outstanding result has come back
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned RANDOM_TABLES   = 6;
  localparam int unsigned ITEMS_PER_TABLE = 240;
  localparam int unsigned EXTREME_ITEMS   = 120;

  // receiver behavior, one mode per stretch of cycles
  typedef enum int unsigned {
    RX_STREAM,
    RX_RANDOM,
    RX_SPARSE,
    RX_HOLD
  } rx_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]      pwdata;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [1:0]             action_i;
  logic [DATA_W-1:0]      address_i;
  logic [DATA_W-1:0]      length_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [DATA_W-1:0]      result_address_o;
  logic                   found_o;
  logic [CHUNK_IDX_W-1:0] chunk_index_o;

  int unsigned            mismatch_count;
  int unsigned            results_outstanding;
  int unsigned            cycle_count = 0;
  int unsigned            burst_left  = 0;

  // the test's own view of the table, used only to aim addresses at chunk edges
  logic [DATA_W-1:0]      table_base [MAX_CHUNKS];
  logic [DATA_W-1:0]      table_size [MAX_CHUNKS];

  always #5 clk_i = ~clk_i;

  memory_chunk_address_translation_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .address_i        (address_i),
    .length_i         (length_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_address_o (result_address_o),
    .found_o          (found_o),
    .chunk_index_o    (chunk_index_o)
  );

  memory_chunk_address_translation_unit_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .address_i        (address_i),
    .length_i         (length_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_address_o (result_address_o),
    .found_o          (found_o),
    .chunk_index_o    (chunk_index_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (results_outstanding)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: stretches of streaming, coin-flip, sparse and held-off ready
  initial begin
    rx_mode_e    mode;
    int unsigned run;
    out_ready_i = 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      run  = (mode == RX_HOLD) ? $urandom_range(1, 20) : $urandom_range(8, 80);
      repeat (run) begin
        @(negedge clk_i);
        case (mode)
          RX_STREAM: out_ready_i = 1'b1;
          RX_RANDOM: out_ready_i = 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i = ($urandom_range(0, 3) == 0);
          default:   out_ready_i = 1'b0;
        endcase
      end
    end
  end

  // setup cycle, then access cycle; the write lands at the edge with penable and pready
  task automatic apb_write(input int unsigned reg_idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'(reg_idx * 4);
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_chunk(input int unsigned c, input logic [DATA_W-1:0] base,
                             input logic [DATA_W-1:0] size);
    apb_write(c * REGS_PER_CHUNK + REG_PHYS_BASE, base);
    apb_write(c * REGS_PER_CHUNK + REG_SIZE, size);
    table_base[c] = base;
    table_size[c] = size;
  endtask

  // sender works in bursts; a new burst may open with a gap of idle cycles
  task automatic send_request(input logic [1:0] act, input logic [DATA_W-1:0] addr,
                              input logic [DATA_W-1:0] len);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 8);
      end
    end
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i   = act;
    address_i  = addr;
    length_i   = len;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  // drop valid and let every outstanding result come back before touching the table
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (results_outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // offsets right at and around both ends of a chunk, or anywhere inside it
  function automatic logic [DATA_W-1:0] near_boundary_offset(input logic [DATA_W-1:0] size);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 1;
      2:       return size - 1;
      3:       return size;
      4:       return size + 1;
      default: return (size == '0) ? '0 : DATA_W'($urandom_range(0, size - 1));
    endcase
  endfunction

  task automatic send_random_item();
    int unsigned       pick;
    int unsigned       c;
    logic [1:0]        act;
    logic [DATA_W-1:0] vstart;
    logic [DATA_W-1:0] off;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 33) begin
      act = ACT_V2P;
    end else if (pick < 66) begin
      act = ACT_P2V;
    end else if (pick < 97) begin
      act = ACT_END;
    end else begin
      act = ACT_UNDEF;
    end
    c      = $urandom_range(0, MAX_CHUNKS - 1);
    vstart = VIRT_BASE_DEF;
    for (int unsigned k = 0; k < c; k++) begin
      vstart = vstart + table_size[k];
    end
    off  = near_boundary_offset(table_size[c]);
    addr = $urandom;
    len  = $urandom;
    // most items aim at a chunk, the rest are plain noise
    if ($urandom_range(0, 4) != 0) begin
      case (act)
        ACT_V2P: addr = vstart + off;
        ACT_P2V: addr = table_base[c] + off;
        ACT_END: begin
          len = table_base[c] + table_size[c] - addr;
          // near misses one byte either side of the chunk end
          if ($urandom_range(0, 3) == 0) begin
            len = len + ($urandom_range(0, 1) ? 32'd1 : ALL_ONES);
          end
        end
        default: ;
      endcase
    end
    send_request(act, addr, len);
  endtask

  // random table: unused, small, mid and huge chunks, some overlapping or wrapping
  task automatic randomize_table();
    int unsigned       kind;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] size;
    for (int unsigned c = 0; c < MAX_CHUNKS; c++) begin
      kind = $urandom_range(0, 5);
      if (c > 0 && kind == 0) begin
        base = table_base[c - 1];
      end else if (kind == 1) begin
        base = ALL_ONES - $urandom_range(0, 32'h2000);
      end else begin
        base = $urandom;
      end
      kind = $urandom_range(0, 19);
      if (kind < 4) begin
        size = '0;
      end else if (kind < 12) begin
        size = $urandom_range(1, 4096);
      end else if (kind < 17) begin
        size = $urandom_range(1, 32'h00FF_FFFF);
      end else begin
        size = $urandom;
      end
      write_chunk(c, base, size);
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    action_i   = ACT_V2P;
    address_i  = '0;
    length_i   = '0;
    for (int unsigned c = 0; c < MAX_CHUNKS; c++) begin
      table_base[c] = '0;
      table_size[c] = '0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // table straight out of reset: every chunk unused, so everything misses,
    // including an end test whose end equals a zero-sized chunk's end
    send_request(ACT_V2P, '0, '0);
    send_request(ACT_P2V, ALL_ONES, ALL_ONES);
    send_request(ACT_END, '0, '0);
    send_request(ACT_UNDEF, '0, '0);
    wait_idle();

    // hand-built table: chunk 1 unused, chunk 3 wraps past the top of memory
    write_chunk(0, 32'h1000_0000, 32'h0000_0100);
    write_chunk(1, 32'h2000_0000, 32'h0000_0000);
    write_chunk(2, 32'h8000_0000, 32'h0000_1000);
    write_chunk(3, 32'hFFFF_F800, 32'h0000_1000);

    // virtual side: chunk 0 is 0..ff, chunk 2 is 100..10ff, chunk 3 is 1100..20ff
    send_request(ACT_V2P, 32'h0000_0000, ALL_ONES);
    send_request(ACT_V2P, 32'h0000_00FF, 32'h0000_0000);
    send_request(ACT_V2P, 32'h0000_0100, 32'h1234_5678);
    send_request(ACT_V2P, 32'h0000_10FF, 32'h0000_0000);
    send_request(ACT_V2P, 32'h0000_1100, 32'h0000_0000);
    send_request(ACT_V2P, 32'h0000_20FF, 32'h0000_0000);
    send_request(ACT_V2P, 32'h0000_2100, 32'h0000_0000);
    send_request(ACT_V2P, ALL_ONES, ALL_ONES);
    // physical side, length carries junk that must not matter
    send_request(ACT_P2V, 32'h1000_0000, ALL_ONES);
    send_request(ACT_P2V, 32'h1000_00FF, 32'hA5A5_5A5A);
    send_request(ACT_P2V, 32'h1000_0100, 32'h0000_0000);
    send_request(ACT_P2V, 32'h2000_0000, 32'h0000_0000);
    send_request(ACT_P2V, 32'h8000_0FFF, 32'h0000_0000);
    send_request(ACT_P2V, 32'hFFFF_F800, 32'h0000_0000);
    send_request(ACT_P2V, 32'h0000_07FF, 32'h0000_0000);
    send_request(ACT_P2V, 32'h0000_0800, 32'h0000_0000);
    // end tests: exact end, unused chunk's end, wrapped end, plain miss
    send_request(ACT_END, 32'h1000_0000, 32'h0000_0100);
    send_request(ACT_END, 32'h2000_0000, 32'h0000_0000);
    send_request(ACT_END, ALL_ONES, 32'h0000_0801);
    send_request(ACT_END, 32'h0000_0000, 32'h0000_0000);
    // undefined action aimed at a real chunk end still misses
    send_request(ACT_UNDEF, 32'h1000_0000, 32'h0000_0100);
    wait_idle();

    // extreme tables: every field at its maximum, then huge chunks from zero
    for (int unsigned c = 0; c < MAX_CHUNKS; c++) begin
      write_chunk(c, ALL_ONES, ALL_ONES);
    end
    repeat (EXTREME_ITEMS) send_random_item();
    wait_idle();
    for (int unsigned c = 0; c < MAX_CHUNKS; c++) begin
      write_chunk(c, '0, ALL_ONES);
    end
    repeat (EXTREME_ITEMS) send_random_item();
    wait_idle();

    repeat (RANDOM_TABLES) begin
      randomize_table();
      repeat (ITEMS_PER_TABLE) send_random_item();
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
